FILE: rtl/weekday_alarm_and_window_events_assert.svh
// Assertion macros shared by the RTL of the weekday alarm block.
// Include guard and synthesis fallback below; no other dependencies.
`ifndef WEEKDAY_ALARM_AND_WINDOW_EVENTS_ASSERT_SVH
`define WEEKDAY_ALARM_AND_WINDOW_EVENTS_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define WAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define WAE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WAE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/wae_pkg.sv
// Package for the weekday alarm block: types, register map, event codes.
// Used by wae_eval and weekday_alarm_and_window_events; no dependencies.
`default_nettype none
package wae_pkg;

    localparam int NUM_ALARMS_MAX = 4;
    localparam int ALARM_W        = 18;
    localparam int HOUR_W         = 5;
    localparam int MIN_W          = 6;
    localparam int WDAY_W         = 3;
    localparam int MOD_W          = 11;
    localparam int MASK_W         = 7;

    localparam logic [31:0]      POLL_INTERVAL_MS = 32'd1000;
    localparam logic [MOD_W-1:0] NO_MINUTE        = 11'd2047;

    // Event set bit positions: alarms in the low bits, then quiet, then period.
    localparam int EV_QUIET  = NUM_ALARMS_MAX;
    localparam int EV_PERIOD = NUM_ALARMS_MAX + 1;
    localparam int EV_BITS   = NUM_ALARMS_MAX + 2;

    localparam logic [1:0] KIND_ALARM       = 2'd0;
    localparam logic [1:0] KIND_QUIET_START = 2'd1;
    localparam logic [1:0] KIND_QUIET_END   = 2'd2;
    localparam logic [1:0] KIND_PERIOD      = 2'd3;

    localparam logic [1:0] PERIOD_NIGHT     = 2'd0;
    localparam logic [1:0] PERIOD_MORNING   = 2'd1;
    localparam logic [1:0] PERIOD_AFTERNOON = 2'd2;
    localparam logic [1:0] PERIOD_EVENING   = 2'd3;

    localparam int          ADDR_W = 5;
    localparam logic [2:0] REG_ALARM_0     = 3'd0;
    localparam logic [2:0] REG_ALARM_1     = 3'd1;
    localparam logic [2:0] REG_ALARM_2     = 3'd2;
    localparam logic [2:0] REG_ALARM_3     = 3'd3;
    localparam logic [2:0] REG_QUIET_START = 3'd4;
    localparam logic [2:0] REG_QUIET_END   = 3'd5;

    localparam logic [HOUR_W-1:0] QUIET_START_RST = 5'd23;
    localparam logic [HOUR_W-1:0] QUIET_END_RST   = 5'd7;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic              clock_ready;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [WDAY_W-1:0] weekday;
    } sample_t;

    typedef struct packed {
        logic [31:0]      last_poll_time;
        logic [MOD_W-1:0] last_minute_of_day;
        logic             quiet_active;
        logic [1:0]       day_period;
    } state_t;

    typedef struct packed {
        logic [EV_BITS-1:0] mask;
        logic               quiet_on;
        logic [1:0]         period;
    } evset_t;

    function automatic logic [1:0] period_of(input logic [HOUR_W-1:0] hour);
        logic [1:0] p;
        if (hour >= 5'd6 && hour < 5'd12) p = PERIOD_MORNING;
        else if (hour >= 5'd12 && hour < 5'd18) p = PERIOD_AFTERNOON;
        else if (hour >= 5'd18 && hour < 5'd23) p = PERIOD_EVENING;
        else p = PERIOD_NIGHT;
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wae_eval.sv
// Evaluation of one sample against the alarm slots, quiet window and period.
// Pure combinational logic; depends on wae_pkg.
`default_nettype none
module wae_eval
    import wae_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_MAX
) (
    input  sample_t                  sample,
    input  state_t                   cur,
    input  logic [ALARM_W-1:0]       alarm [NUM_ALARMS_MAX],
    input  logic [HOUR_W-1:0]        quiet_start,
    input  logic [HOUR_W-1:0]        quiet_end,
    output state_t                   nxt,
    output evset_t                   events
);

    logic [31:0]         elapsed;
    logic                poll_ok;
    logic [MOD_W-1:0]    minute_of_day;
    logic                new_minute;
    logic                quiet;
    logic [1:0]          period;
    logic [NUM_ALARMS_MAX-1:0] hits;

    // Hour times 60 as hour*64 - hour*4.
    assign minute_of_day = {sample.hour, 6'd0} - MOD_W'({sample.hour, 2'd0})
                           + MOD_W'(sample.minute);
    assign elapsed    = sample.now_ms - cur.last_poll_time;
    assign poll_ok    = sample.clock_ready && (elapsed >= POLL_INTERVAL_MS);
    assign new_minute = poll_ok && (minute_of_day != cur.last_minute_of_day);

    always_comb
    begin
        if (quiet_start <= quiet_end)
        begin
            quiet = (sample.hour >= quiet_start) && (sample.hour < quiet_end);
        end
        else
        begin
            quiet = (sample.hour >= quiet_start) || (sample.hour < quiet_end);
        end
    end

    assign period = period_of(sample.hour);

    genvar i;
    generate
        for (i = 0; i < NUM_ALARMS_MAX; i++) begin : g_slot
            logic [MASK_W:0] day_mask;
            assign day_mask = {1'b0, alarm[i][MASK_W-1:0]};
            if (i < NUM_ALARMS) begin : g_on
                // Weekday 7 lands on the padding zero and matches nothing.
                assign hits[i] = (alarm[i][MASK_W-1:0] != '0)
                                 && (alarm[i][ALARM_W-1 -: HOUR_W] == sample.hour)
                                 && (alarm[i][MASK_W +: MIN_W] == sample.minute)
                                 && day_mask[sample.weekday];
            end
            else begin : g_off
                assign hits[i] = 1'b0 & day_mask[0];
            end
        end
    endgenerate

    always_comb
    begin
        nxt         = cur;
        events.mask = '0;
        events.quiet_on = quiet;
        events.period   = period;
        if (poll_ok)
        begin
            nxt.last_poll_time = sample.now_ms;
        end
        if (new_minute)
        begin
            nxt.last_minute_of_day = minute_of_day;
            nxt.quiet_active       = quiet;
            nxt.day_period         = period;
            events.mask[NUM_ALARMS_MAX-1:0] = hits;
            events.mask[EV_QUIET]  = (quiet != cur.quiet_active);
            events.mask[EV_PERIOD] = (period != cur.day_period);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/weekday_alarm_and_window_events.sv
// Top level of the weekday alarm and quiet-window event block.
// Instantiates wae_eval; depends on wae_pkg and the assertion macro header.
//
// Usage: samples arrive on the s_ stream (one sample per transaction), events
// leave on the m_ stream (one event per transaction, m_tlast on the last event
// of a sample). The user must set alarm slots and quiet hours through the APB
// port while the block is idle; the block itself does not enforce this.
// Path: a sample waits in the input register, where it is evaluated, and its events
// go to the event register, which drives m_tvalid; a sample that causes no event
// leaves the input register and offers nothing. Throughput: one sample per cycle
// when it causes at most one event and m_tready is high; a sample with n events
// (up to 6) holds the result channel until its last event is taken. This is set
// by the result channel, which moves one event per cycle out of the event register
// while m_tready is high and the next sample waits in the input register.
// Reset: configuration returns to defaults (alarms off, quiet 23 to 7), no
// poll recorded, no minute checked, not quiet, night period.
// Stall: while m_tready is low the current event holds; one more sample is
// taken into the input register, after which s_tready stays low.
`default_nettype none
`include "weekday_alarm_and_window_events_assert.svh"
module weekday_alarm_and_window_events
    import wae_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_MAX
) (
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Sample stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // now_ms[31:0], sample_hour[36:32],
                                         // sample_minute[42:37], weekday[45:43], zeros
    input  logic              s_tuser,   // clock_ready
    // Event stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // event_value[1:0], zeros
    output logic [1:0]        m_tuser,   // event_kind[1:0]
    output logic              m_tlast    // last_event
);

    logic [ALARM_W-1:0] alarm_reg [NUM_ALARMS_MAX];
    logic [HOUR_W-1:0]  quiet_start_reg;
    logic [HOUR_W-1:0]  quiet_end_reg;

    logic               in_valid_reg;
    sample_t            in_sample_reg;
    state_t             state_reg;
    state_t             state_next;
    evset_t             eval_events;
    logic [EV_BITS-1:0] pend_mask_reg;
    logic [EV_BITS-1:0] pend_mask_next;
    logic               pend_quiet_on_reg;
    logic [1:0]         pend_period_reg;

    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic               advance;
    logic               out_fire;
    logic [EV_BITS-1:0] low_bit;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ALARMS_MAX; k++)
            begin
                alarm_reg[k] <= '0;
            end
            quiet_start_reg <= QUIET_START_RST;
            quiet_end_reg   <= QUIET_END_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_ALARM_0, REG_ALARM_1, REG_ALARM_2, REG_ALARM_3:
                    alarm_reg[cfg_index[1:0]] <= pwdata[ALARM_W-1:0];
                REG_QUIET_START: quiet_start_reg <= pwdata[HOUR_W-1:0];
                REG_QUIET_END:   quiet_end_reg   <= pwdata[HOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index) inside
            REG_ALARM_0, REG_ALARM_1, REG_ALARM_2, REG_ALARM_3:
                prdata = 32'(alarm_reg[cfg_index[1:0]]);
            REG_QUIET_START: prdata = 32'(quiet_start_reg);
            REG_QUIET_END:   prdata = 32'(quiet_end_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    // The buffered sample moves on once the event register is empty or
    // hands over its last event in this cycle.
    assign out_fire = m_tvalid && m_tready;
    assign advance  = in_valid_reg && ((pend_mask_reg == '0) || (out_fire && m_tlast));
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg.now_ms      <= s_tdata[31:0];
            in_sample_reg.clock_ready <= s_tuser;
            in_sample_reg.hour        <= s_tdata[36:32];
            in_sample_reg.minute      <= s_tdata[42:37];
            in_sample_reg.weekday     <= s_tdata[45:43];
        end
    end

    // ---------------- evaluation ----------------
    wae_eval #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_eval (
        .sample      (in_sample_reg),
        .cur         (state_reg),
        .alarm       (alarm_reg),
        .quiet_start (quiet_start_reg),
        .quiet_end   (quiet_end_reg),
        .nxt         (state_next),
        .events      (eval_events)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_poll_time     <= '0;
            state_reg.last_minute_of_day <= NO_MINUTE;
            state_reg.quiet_active       <= 1'b0;
            state_reg.day_period         <= PERIOD_NIGHT;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- event register and drain ----------------
    assign low_bit = pend_mask_reg & (~pend_mask_reg + EV_BITS'(1));

    always_comb
    begin
        pend_mask_next = pend_mask_reg;
        if (advance)
        begin
            pend_mask_next = eval_events.mask;
        end
        else if (out_fire)
        begin
            pend_mask_next = pend_mask_reg & ~low_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg <= '0;
        end
        else
        begin
            pend_mask_reg <= pend_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pend_quiet_on_reg <= eval_events.quiet_on;
            pend_period_reg   <= eval_events.period;
        end
    end

    assign m_tvalid = (pend_mask_reg != '0);
    assign m_tlast  = (pend_mask_reg & ~low_bit) == '0;

    always_comb
    begin
        m_tuser = KIND_PERIOD;
        m_tdata = '0;
        if (pend_mask_reg[NUM_ALARMS_MAX-1:0] != '0)
        begin
            m_tuser = KIND_ALARM;
            for (int k = NUM_ALARMS_MAX - 1; k >= 0; k--)
            begin
                if (pend_mask_reg[k])
                begin
                    m_tdata = 8'(k);
                end
            end
        end
        else if (pend_mask_reg[EV_QUIET])
        begin
            m_tuser = pend_quiet_on_reg ? KIND_QUIET_START : KIND_QUIET_END;
        end
        else
        begin
            m_tdata = 8'(pend_period_reg);
        end
    end

    // ---------------- assertions ----------------
    `WAE_ASSERT_IMP(a_stall_only_when_draining, clk, rst_n, !s_tready,
        in_valid_reg && m_tvalid, "input stalled without a pending event")
    `WAE_ASSERT_NXT(a_more_events_follow, clk, rst_n, out_fire && !m_tlast,
        m_tvalid, "event set ended before its last event")
    `WAE_ASSERT_NXT(a_events_loaded, clk, rst_n, advance && (eval_events.mask != '0),
        m_tvalid, "evaluated events were not offered")

endmodule
`default_nettype wire
